>>> src/audio_tempo_rate_controller_assert.svh
// Assertion macros used by the checker file.
`ifndef AUDIO_TEMPO_RATE_CONTROLLER_ASSERT_SVH
`define AUDIO_TEMPO_RATE_CONTROLLER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ATRC_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ATRC_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

>>> src/atrc_pkg.sv
// Package with constants and types of the audio tempo rate controller.
package atrc_pkg;
  localparam int unsigned WindowMaxDefault = 10;
  localparam logic [19:0] Q16One      = 20'd65536;
  localparam logic [19:0] AdjMax      = 20'hFFFFF;
  localparam logic [19:0] UpOffset    = 20'd5243;
  localparam logic [19:0] DownOffset  = 20'd2621;
  localparam logic [19:0] AdjHigh     = 20'd196608;
  localparam logic [8:0]  ReturnStep  = 9'd10;

  localparam logic [1:0] RegLowWater  = 2'd0;
  localparam logic [1:0] RegHighWater = 2'd1;
  localparam logic [1:0] RegGameRate  = 2'd2;
  localparam logic [1:0] RegWinLen    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_MUL, ST_DIV, ST_DECIDE, ST_TEMPO, ST_OUT
  } state_e;
endpackage

>>> src/audio_tempo_rate_controller.sv
// Audio tempo rate controller: windowed ratio, drain control and slow tempo.
// The window sum walks the filled window slots one per cycle, then a shift-subtract
// divider yields one quotient bit per cycle over 56 steps.
// A new request is accepted only once the previous result has been taken.
// Reset (rst_ni low, asynchronous) restores the register defaults and state.
module audio_tempo_rate_controller #(
  parameter int unsigned WINDOW_MAX = atrc_pkg::WindowMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] queue_level, [27:8] feed_time_us, [45:30] chunk_bytes, zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [8:0] tempo_percent, [9] tempo_written, [10] draining, zero fill
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import atrc_pkg::*;

  localparam int unsigned PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned NB = 56;

  state_e state_q, state_d;
  logic [7:0]  low_q, high_q;
  logic [16:0] rate_q;
  logic [3:0]  wlen_q;
  logic [19:0] feed_win_q [WINDOW_MAX];
  logic [15:0] samp_win_q [WINDOW_MAX];
  logic [PW-1:0] pos_q;
  logic full_q, first_q, drain_q;
  logic [8:0]  slow_q;
  logic [19:0] adj_q;
  logic [7:0]  queue_q;
  logic [19:0] feed_q;
  logic [15:0] smp_q;
  logic [CW-1:0] cnt_q, idx_q;
  logic [23:0] fsum_q;
  logic [19:0] ssum_q;
  logic [55:0] num_q;
  logic [40:0] den_q;
  logic [56:0] rem_q;
  logic [55:0] quo_q;
  logic [5:0]  step_q;
  logic [19:0] ratio_q;
  logic        written_q;
  logic [CW-1:0] wl;

  always_comb begin
    wl = CW'(wlen_q);
    if (wlen_q == 4'd0) wl = CW'(1);
    if ({28'd0, wlen_q} > WINDOW_MAX) wl = CW'(WINDOW_MAX);
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;
  // Registers change only between requests.
  assign cfg_ready_o   = (state_q == ST_IDLE) && !s_axis_tvalid;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {5'd0, drain_q, written_q, slow_q};

  // Shifted partial remainder fed to the divider's subtractor.
  logic [56:0] trial;
  assign trial = {rem_q[55:0], num_q[NB-1]};

  // Decision logic, computed from the ratio register.
  logic dry;
  logic [20:0] up;
  logic [19:0] adj_n;
  logic drain_n;
  always_comb begin
    dry = queue_q < low_q;
    up = {1'b0, ratio_q} + {1'b0, UpOffset};
    adj_n = adj_q;
    drain_n = drain_q;
    if ((queue_q > high_q || drain_q) && !dry) begin
      drain_n = 1'b1;
      adj_n = up[20] ? AdjMax : up[19:0];
    end else if (dry) begin
      drain_n = 1'b0;
      adj_n = (ratio_q > DownOffset) ? ratio_q - DownOffset : 20'd0;
    end else if (queue_q < high_q) begin
      adj_n = ratio_q;
    end
  end

  // Tempo step from the stored adjustment.
  logic [26:0] a100, s100, one100, da, ds;
  logic [8:0] pct;
  logic in_rng;
  always_comb begin
    a100   = 27'(adj_q) * 27'd100;
    s100   = {2'd0, slow_q, 16'd0};
    one100 = 27'd6553600;
    da = (a100 > one100) ? a100 - one100 : one100 - a100;
    ds = (s100 > one100) ? s100 - one100 : one100 - s100;
    in_rng = ({3'd0, adj_q} * 23'd5 > 23'(Q16One)) && (adj_q < AdjHigh);
    if (da < ds && a100 > s100 && (a100 - s100) > 27'(10 * 65536))
      pct = slow_q + ReturnStep;
    else
      pct = a100[24:16];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid && s_axis_tready) state_d = ST_SUM;
      ST_SUM:    if (idx_q >= cnt_q) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    if (step_q == 6'd0) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_TEMPO;
      ST_TEMPO:  state_d = ST_OUT;
      ST_OUT:    if (m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      low_q <= 8'd20; high_q <= 8'd50; rate_q <= 17'd33600; wlen_q <= 4'd10;
      pos_q <= '0; full_q <= 1'b0; first_q <= 1'b1; drain_q <= 1'b0;
      slow_q <= 9'd100; adj_q <= Q16One;
      cnt_q <= '0; den_q <= '0; num_q <= '0; rem_q <= '0; quo_q <= '0;
      step_q <= '0; ratio_q <= '0; written_q <= 1'b0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
        feed_win_q[i] <= '0;
        samp_win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegLowWater:  low_q  <= cfg_data_i[7:0];
          RegHighWater: high_q <= cfg_data_i[7:0];
          RegGameRate:  rate_q <= cfg_data_i;
          RegWinLen:    wlen_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
        if (CW'(pos_q) >= wl) begin
          pos_q <= '0; full_q <= 1'b1; cnt_q <= wl;
        end else begin
          cnt_q <= full_q ? wl : CW'(pos_q);
        end
      end
      if (state_q == ST_MUL) begin
        den_q <= 41'((rate_q == 17'd0) ? 17'd1 : rate_q) * 41'(fsum_q);
        num_q <= 56'(ssum_q) * 56'd65536000000;
        rem_q <= '0;
        quo_q <= '0;
        step_q <= 6'(NB);
      end
      if (state_q == ST_DIV) begin
        if (step_q != 6'd0) begin
          num_q <= num_q << 1;
          if (trial >= {16'd0, den_q}) begin
            rem_q <= trial - {16'd0, den_q};
            quo_q <= {quo_q[54:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[54:0], 1'b0};
          end
          step_q <= step_q - 6'd1;
        end else begin
          if (first_q || cnt_q == '0) ratio_q <= Q16One;
          else if (fsum_q == '0 || quo_q > 56'(AdjMax)) ratio_q <= AdjMax;
          else ratio_q <= quo_q[19:0];
        end
      end
      if (state_q == ST_DECIDE) begin
        adj_q <= adj_n;
        drain_q <= drain_n;
      end
      if (state_q == ST_TEMPO) begin
        written_q <= in_rng;
        if (in_rng) slow_q <= {pct[8:2], 2'b00};
        if (feed_q != 20'd0) feed_win_q[pos_q] <= feed_q;
        samp_win_q[pos_q] <= smp_q;
        first_q <= 1'b0;
        if (CW'(pos_q) + CW'(1) >= wl) begin
          pos_q <= '0; full_q <= 1'b1;
        end else begin
          pos_q <= pos_q + PW'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
      queue_q <= s_axis_tdata[7:0];
      feed_q  <= s_axis_tdata[27:8];
      smp_q   <= s_axis_tdata[45:30];
      idx_q   <= '0;
      fsum_q  <= '0;
      ssum_q  <= '0;
    end
    if (state_q == ST_SUM && idx_q < cnt_q) begin
      fsum_q <= fsum_q + 24'(feed_win_q[idx_q[PW-1:0]]);
      ssum_q <= ssum_q + 20'(samp_win_q[idx_q[PW-1:0]]);
      idx_q  <= idx_q + CW'(1);
    end
  end
endmodule

>>> src/atrc_checker.sv
// Port checker for the audio tempo rate controller, bound to the top level.
`include "audio_tempo_rate_controller_assert.svh"
module atrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  `ATRC_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `ATRC_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "block not busy after request")
  `ATRC_ASSERT_IMP(a_tempo_quant, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] == 2'b00 && m_axis_tdata[15:11] == 5'd0, "tempo not a multiple of four")
  `ATRC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind audio_tempo_rate_controller atrc_checker u_atrc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
